[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the rational arithmetic unit.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check, clocked on clk_i, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/rau_pkg.sv]
// Package for the rational arithmetic unit: widths and command codes.
// Depends on nothing.
package rau_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned NumBits = 34;
  localparam int unsigned DenBits = 31;
  localparam int unsigned CmdBits = 3;
  localparam logic [CmdBits-1:0] CmdAdd = 3'd0;
  localparam logic [CmdBits-1:0] CmdSub = 3'd1;
  localparam logic [CmdBits-1:0] CmdMul = 3'd2;
  localparam logic [CmdBits-1:0] CmdDiv = 3'd3;
  localparam logic [CmdBits-1:0] CmdCmp = 3'd4;
  // shared divider request: a start strobe only; operands and results travel on the divider ports
  typedef struct packed {
    logic start;
  } div_ctl_t;
endpackage

[rtl/rau_divider.sv]
// Shared restoring divider for the rational arithmetic unit: one bit a cycle.
// Depends on rau_pkg.
module rau_divider #(
  parameter int unsigned W = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rau_pkg::div_ctl_t ctl_i,
  input  logic [W-1:0]     dividend_i,
  input  logic [W-1:0]     divisor_i,
  output logic             done_o,
  output logic [W-1:0]     quot_o,
  output logic [W-1:0]     rem_o
);
  import rau_pkg::*;
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] q_q, q_d, r_q, r_d, dv_q, dv_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic run_q, run_d, done_q, done_d;
  logic [W:0] sh;
  logic [W:0] diff;

  always_comb begin
    q_d = q_q; r_d = r_q; dv_d = dv_q; cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    sh = {r_q, q_q[W-1]};
    diff = sh - {1'b0, dv_q};
    if (ctl_i.start) begin
      q_d = dividend_i; r_d = '0; dv_d = divisor_i; cnt_d = CW'(W); run_d = 1'b1;
    end else if (run_q) begin
      if (!diff[W]) begin
        r_d = diff[W-1:0]; q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = sh[W-1:0]; q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o = r_q;
endmodule

[rtl/rational_arith_unit_core.sv]
// Rational arithmetic unit: add, subtract, multiply, divide, equality compare.
// Timing: data dependent; each divider pass and Euclid step uses the shared divider
// (W = 2*OPERAND_WIDTH+2, 34 by default), over up to four GCD/reduction rounds; busy
// high meanwhile.
// Throughput: one transaction at a time; the next may be taken in the strobe cycle.
// Reset: asynchronous, active low; sequencer idle, no strobe. The receiver cannot stall.
module rational_arith_unit_core #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rau_pkg::CmdBits-1:0] cmd_i,
  input  logic signed [OPERAND_WIDTH-1:0] lhs_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] lhs_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] rhs_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] rhs_den_i,
  output logic                        done_o,
  output logic signed [rau_pkg::NumBits-1:0] res_num_o,
  output logic [rau_pkg::DenBits-1:0] res_den_o,
  output logic                        is_equal_o,
  output logic                        status_o
);
  import rau_pkg::*;
  `include "assert_macros.svh"
  // magnitudes fit 2*OPERAND_WIDTH+2 bits through every step
  localparam int unsigned W = 2 * OPERAND_WIDTH + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GCD = 4'd1;   // Euclid: b <= a % b
  localparam logic [3:0] S_DIVN = 4'd2;  // numerator / gcd
  localparam logic [3:0] S_DIVD = 4'd3;  // denominator / gcd
  localparam logic [3:0] S_NEXT = 4'd4;  // choose next job after a reduction
  localparam logic [3:0] S_LCD = 4'd5;   // la = b.den / g
  localparam logic [3:0] S_LCD2 = 4'd6;  // lb = a.den / g
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_WAIT = 4'd10;
  localparam logic [3:0] S_MUL3 = 4'd11; // add/sub: second cross product and combine

  // jobs in order of a transaction
  localparam logic [2:0] J_LOADL = 3'd0;
  localparam logic [2:0] J_LOADR = 3'd1;
  localparam logic [2:0] J_LCD = 3'd2;
  localparam logic [2:0] J_FINAL = 3'd3;

  logic [3:0] st_q, st_d, ret_q, ret_d;
  logic [2:0] job_q, job_d;
  logic [CmdBits-1:0] cmd_q, cmd_d;
  logic [W-1:0] ln_q, ln_d, ld_q, ld_d, rn_q, rn_d, rd_q, rd_d;
  logic ls_q, ls_d, rs_q, rs_d;
  logic [W-1:0] ga_q, ga_d, gb_q, gb_d;      // Euclid pair
  logic [W-1:0] xn_q, xn_d, xd_q, xd_d;      // value under reduction
  logic xs_q, xs_d;
  logic [W-1:0] la_q, la_d, lb_q, lb_d;
  logic err_q, err_d, eq_q, eq_d;
  logic done_q, done_d;
  div_ctl_t dctl;
  logic [W-1:0] dvd, dvs, quot, rem;
  logic ddone;

  rau_divider #(.W(W)) u_div (
    .clk_i, .rst_ni, .ctl_i(dctl), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(ddone), .quot_o(quot), .rem_o(rem)
  );

  function automatic logic [W-1:0] mag(input logic [OPERAND_WIDTH-1:0] v);
    logic [OPERAND_WIDTH:0] e;
    e = {v[OPERAND_WIDTH-1], v};
    if (v[OPERAND_WIDTH-1]) e = -e;
    return W'(e);
  endfunction

  // One shared multiplier; every factor is a reduced magnitude below 2^OPERAND_WIDTH+1,
  // so the product fits W bits.
  logic [OPERAND_WIDTH:0] pa, pb;
  logic [W-1:0] prod;
  assign prod = W'(pa) * W'(pb);

  always_comb begin
    st_d = st_q; ret_d = ret_q; job_d = job_q; cmd_d = cmd_q;
    ln_d = ln_q; ld_d = ld_q; rn_d = rn_q; rd_d = rd_q; ls_d = ls_q; rs_d = rs_q;
    ga_d = ga_q; gb_d = gb_q; xn_d = xn_q; xd_d = xd_q; xs_d = xs_q;
    la_d = la_q; lb_d = lb_q; err_d = err_q; eq_d = eq_q; done_d = 1'b0;
    dctl.start = 1'b0; dvd = ga_q; dvs = gb_q;
    pa = '0; pb = '0;
    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          ln_d = mag(lhs_num_i); ld_d = mag(lhs_den_i);
          rn_d = mag(rhs_num_i); rd_d = mag(rhs_den_i);
          ls_d = lhs_num_i[OPERAND_WIDTH-1] ^ lhs_den_i[OPERAND_WIDTH-1];
          rs_d = rhs_num_i[OPERAND_WIDTH-1] ^ rhs_den_i[OPERAND_WIDTH-1];
          err_d = (lhs_den_i == '0) || (rhs_den_i == '0) || (cmd_i > CmdCmp);
          eq_d = 1'b0;
          // load the left operand for reduction
          xn_d = mag(lhs_num_i); xd_d = mag(lhs_den_i);
          xs_d = lhs_num_i[OPERAND_WIDTH-1] ^ lhs_den_i[OPERAND_WIDTH-1];
          ga_d = mag(lhs_num_i); gb_d = mag(lhs_den_i);
          job_d = J_LOADL;
          st_d = S_GCD;
          if ((lhs_den_i == '0) || (rhs_den_i == '0) || (cmd_i > CmdCmp)) st_d = S_OUT;
        end
      end
      S_GCD: begin
        // gcd(a,b): loop while b != 0
        if (gb_q == '0) begin
          if (ga_q == '0) ga_d = W'(1);
          st_d = ret_q;
        end else begin
          dctl.start = 1'b1; st_d = S_WAIT; ret_d = ret_q;
        end
      end
      S_WAIT: begin
        if (ddone) begin
          ga_d = gb_q; gb_d = rem; st_d = S_GCD;
        end
      end
      S_DIVN: begin
        // xn / g then xd / g, both through the divider; ret_q marks the first issue
        if (ret_q == S_DIVN) begin
          dvd = xn_q; dvs = ga_q; dctl.start = 1'b1; ret_d = S_DIVD;
        end else if (ddone) begin
          xn_d = quot; dvd = xd_q; dvs = ga_q; dctl.start = 1'b1; st_d = S_DIVD;
        end
      end
      S_DIVD: begin
        if (ddone) begin
          xd_d = quot; st_d = S_NEXT;
          if (xn_q == '0) xs_d = 1'b0;
        end
      end
      S_NEXT: begin
        ret_d = S_DIVN;
        unique case (job_q)
          J_LOADL: begin
            ln_d = xn_q; ld_d = xd_q; ls_d = xs_q;
            xn_d = rn_q; xd_d = rd_q; xs_d = rs_q; ga_d = rn_q; gb_d = rd_q;
            job_d = J_LOADR; st_d = S_GCD;
          end
          J_LOADR: begin
            rn_d = xn_q; rd_d = xd_q;
            rs_d = (xn_q != '0) && (cmd_q == CmdSub ? !xs_q : xs_q);
            unique case (cmd_q) inside
              CmdAdd, CmdSub: begin
                ga_d = ld_q; gb_d = xd_q; ret_d = S_LCD; st_d = S_GCD; job_d = J_LCD;
              end
              CmdCmp: begin
                eq_d = (ls_q == xs_q) && (ln_q == xn_q) && (ld_q == xd_q);
                st_d = S_OUT;
              end
              CmdDiv: begin
                if (xn_q == '0) begin
                  err_d = 1'b1; st_d = S_OUT;
                end else st_d = S_MUL1;
              end
              default: st_d = S_MUL1;
            endcase
          end
          default: st_d = S_OUT;
        endcase
      end
      S_LCD: begin
        // g in ga_q; la = rd/g
        if (!ddone && ret_q != S_LCD2) begin
          dvd = rd_q; dvs = ga_q; dctl.start = 1'b1; ret_d = S_LCD2;
        end else if (ddone) begin
          la_d = quot; dvd = ld_q; dvs = ga_q; dctl.start = 1'b1; st_d = S_LCD2;
        end
      end
      S_LCD2: begin
        if (ddone) begin
          lb_d = quot; st_d = S_MUL1;
        end
      end
      S_MUL1: begin
        // first product: denominator
        unique case (cmd_q)
          CmdMul: begin pa = ld_q[OPERAND_WIDTH:0]; pb = rd_q[OPERAND_WIDTH:0]; end
          CmdDiv: begin pa = ld_q[OPERAND_WIDTH:0]; pb = rn_q[OPERAND_WIDTH:0]; end
          default: begin pa = ld_q[OPERAND_WIDTH:0]; pb = la_q[OPERAND_WIDTH:0]; end
        endcase
        xd_d = prod;
        st_d = S_MUL2;
      end
      S_MUL2: begin
        job_d = J_FINAL; ret_d = S_DIVN; st_d = S_GCD;
        unique case (cmd_q)
          CmdMul: begin
            pa = ln_q[OPERAND_WIDTH:0]; pb = rn_q[OPERAND_WIDTH:0];
            xn_d = prod; xs_d = ls_q ^ rs_q;
          end
          CmdDiv: begin
            pa = ln_q[OPERAND_WIDTH:0]; pb = rd_q[OPERAND_WIDTH:0];
            xn_d = prod; xs_d = ls_q ^ rs_q;
          end
          default: begin
            // hold x = ln*la in xn; y follows next cycle
            pa = ln_q[OPERAND_WIDTH:0]; pb = la_q[OPERAND_WIDTH:0];
            xn_d = prod; st_d = S_MUL3;
          end
        endcase
        ga_d = xn_d; gb_d = xd_q;
      end
      S_MUL3: begin
        // y = rn*lb; combine by sign, larger magnitude keeps its sign
        pa = rn_q[OPERAND_WIDTH:0]; pb = lb_q[OPERAND_WIDTH:0];
        if (ls_q == rs_q) begin
          xn_d = xn_q + prod; xs_d = ls_q;
        end else if (xn_q >= prod) begin
          xn_d = xn_q - prod; xs_d = ls_q;
        end else begin
          xn_d = prod - xn_q; xs_d = rs_q;
        end
        ga_d = xn_d; gb_d = xd_q; st_d = S_GCD;
      end
      S_OUT: begin
        done_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ret_q <= S_DIVN; job_q <= J_LOADL; done_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; job_q <= job_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ln_q <= ln_d; ld_q <= ld_d; rn_q <= rn_d; rd_q <= rd_d;
    ls_q <= ls_d; rs_q <= rs_d; ga_q <= ga_d; gb_q <= gb_d;
    xn_q <= xn_d; xd_q <= xd_d; xs_q <= xs_d; la_q <= la_d; lb_q <= lb_d;
    err_q <= err_d; eq_q <= eq_d;
  end

  logic [W-1:0] sn;
  assign sn = xs_q ? (W'(0) - xn_q) : xn_q;
  assign busy = (st_q != S_IDLE);
  assign done_o = done_q;
  assign status_o = err_q;
  assign is_equal_o = !err_q && (cmd_q == CmdCmp) && eq_q;
  assign res_num_o = (err_q || cmd_q == CmdCmp) ? '0 : NumBits'(sn);
  assign res_den_o = err_q ? '0 : (cmd_q == CmdCmp) ? DenBits'(1) : DenBits'(xd_q);

  `ASSERT_IMPL(a_done_idle, done_q, !busy)
  `ASSERT_IMPL(a_err_den, done_q && !status_o, res_den_o != '0)
  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
endmodule
